>>> hw/rtl/sbph_pkg.sv
package sbph_pkg;

   // Field widths
   localparam int BIN_W     = 5;
   localparam int AMP_W     = 20;
   localparam int LEVEL_W   = 4;
   localparam int GAIN_W    = 7;

   // Meter geometry
   localparam int NUM_BINS  = 32;
   localparam int IDX_W     = $clog2(NUM_BINS);
   localparam int MAX_LEVEL = 15;

   // Serial quotient: one bit per step, divisor pre-shifted to the top bit
   localparam int QUO_W     = $clog2(MAX_LEVEL + 1);
   localparam int STEP_W    = (QUO_W > 1) ? $clog2(QUO_W) : 1;
   localparam int DIV_W     = GAIN_W + QUO_W - 1;
   localparam int CMP_W     = (AMP_W > DIV_W) ? AMP_W : DIV_W;
   localparam int SAT_W     = (AMP_W > GAIN_W + QUO_W) ? AMP_W : GAIN_W + QUO_W;

   // Register file
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DIVISOR = '0;
   localparam logic [GAIN_W-1:0]    GAIN_RESET       = GAIN_W'(1);

   // Word kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef struct packed {
      logic              start;
      logic [AMP_W-1:0]  amp;
      logic [GAIN_W-1:0] gain;
   } sbph_div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] level;
   } sbph_div_res_type;

   typedef struct packed {
      logic               update;
      logic               decay;
      logic [BIN_W-1:0]   bin;
      logic [LEVEL_W-1:0] level;
   } sbph_peak_cmd_type;

endpackage

>>> hw/rtl/sbph_if.sv
interface sbph_req_if;
   import sbph_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BIN_W-1:0]  bin_index;
   logic [AMP_W-1:0]  amplitude;

   modport source (output valid, req_type, bin_index, amplitude, input ready);
   modport sink   (input valid, req_type, bin_index, amplitude, output ready);
endinterface

interface sbph_rsp_if;
   import sbph_pkg::*;

   logic               valid;
   logic               ready;
   logic [BIN_W-1:0]   bin_out;
   logic [LEVEL_W-1:0] bar_height;
   logic [LEVEL_W-1:0] peak_height;

   modport source (output valid, bin_out, bar_height, peak_height, input ready);
   modport sink   (input valid, bin_out, bar_height, peak_height, output ready);
endinterface

>>> hw/rtl/sbph_serial_div.sv
module sbph_serial_div (
   input  logic                       clock,
   input  logic                       reset,
   input  sbph_pkg::sbph_div_cmd_type cmd,
   output sbph_pkg::sbph_div_res_type res
);
   import sbph_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} div_state_type;

   div_state_type       state_ff;
   logic [AMP_W-1:0]    rem_ff;
   logic [DIV_W-1:0]    div_ff;
   logic [QUO_W-1:0]    q_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                sat_ff;
   logic                done_ff;
   logic [LEVEL_W-1:0]  level_ff;

   logic [CMP_W-1:0]    rem_ext;
   logic [CMP_W-1:0]    div_ext;
   logic                take;
   logic [AMP_W-1:0]    rem_in;
   logic [QUO_W-1:0]    q_in;
   logic                sat_in;
   logic [LEVEL_W-1:0]  level_in;

   // Saturate when the quotient cannot fit, or on a zero divisor
   always_comb begin
      sat_in = (cmd.gain == '0) ||
               (SAT_W'(cmd.amp) >= (SAT_W'(cmd.gain) << QUO_W));
   end

   // One restoring step: compare, subtract, shift in a quotient bit
   always_comb begin
      rem_ext = CMP_W'(rem_ff);
      div_ext = CMP_W'(div_ff);
      take    = rem_ext >= div_ext;
      rem_in  = take ? AMP_W'(rem_ext - div_ext) : rem_ff;
      q_in    = {q_ff[QUO_W-2:0], take};
      if (sat_ff || (QUO_W'(q_in) > QUO_W'(MAX_LEVEL))) begin
         level_in = LEVEL_W'(MAX_LEVEL);
      end else begin
         level_in = LEVEL_W'(q_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            D_IDLE: begin
               done_ff <= 1'b0;
               if (cmd.start) begin
                  rem_ff   <= cmd.amp;
                  div_ff   <= DIV_W'(cmd.gain) << (QUO_W - 1);
                  q_ff     <= '0;
                  sat_ff   <= sat_in;
                  step_ff  <= STEP_W'(QUO_W - 1);
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= rem_in;
               div_ff <= div_ff >> 1;
               q_ff   <= q_in;
               if (step_ff == '0) begin
                  level_ff <= level_in;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= D_IDLE;
               done_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign res.done  = done_ff;
   assign res.level = level_ff;

endmodule

>>> hw/rtl/sbph_peak_store.sv
module sbph_peak_store (
   input  logic                        clock,
   input  logic                        reset,
   input  sbph_pkg::sbph_peak_cmd_type cmd,
   output logic [sbph_pkg::LEVEL_W-1:0] peak_new
);
   import sbph_pkg::*;

   logic [LEVEL_W-1:0] peak_ff [NUM_BINS];

   logic               in_range;
   logic [IDX_W-1:0]   idx;
   logic [LEVEL_W-1:0] cur;
   logic               raise;

   always_comb begin
      in_range = int'(cmd.bin) < NUM_BINS;
      idx      = IDX_W'(cmd.bin);
      cur      = peak_ff[idx];
      raise    = in_range && (cur < cmd.level);
      if (!in_range) begin
         peak_new = '0;
      end else if (raise) begin
         peak_new = cmd.level;
      end else begin
         peak_new = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            peak_ff[i] <= '0;
         end
      end else if (cmd.decay) begin
         // Drop every lit peak by one step
         for (int i = 0; i < NUM_BINS; i++) begin
            if (peak_ff[i] != '0) begin
               peak_ff[i] <= peak_ff[i] - 1'b1;
            end
         end
      end else if (cmd.update && raise) begin
         peak_ff[idx] <= cmd.level;
      end
   end

endmodule

>>> hw/rtl/spectrum_bar_peak_hold.sv
// Channel   Dir  Handshake          Word
// req_port  in   valid/ready        req_type, bin_index, amplitude
// rsp_port  out  valid/ready        bin_out, bar_height, peak_height
// csr_*     in   APB, pready high   gain_divisor at byte 0
//
// A sample word passes through loading the quotient unit, four restoring steps
// (one quotient bit each), then updating the peak and loading the result
// register, which waits while a result is held. A tick word is done on acceptance.
// Reset is synchronous; it clears all held peaks at once and sets gain to 1.
// A result waiting on rsp_port stalls the completion of the next sample and,
// with it, the acceptance of any tick or sample word after that sample.
module spectrum_bar_peak_hold (
   input  logic                                clock,
   input  logic                                reset,
   sbph_req_if.sink                            req_port,
   sbph_rsp_if.source                          rsp_port,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sbph_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sbph_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sbph_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import sbph_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} top_state_type;

   top_state_type       state_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [BIN_W-1:0]    bin_ff;
   logic                rsp_valid_ff;
   logic [BIN_W-1:0]    rsp_bin_ff;
   logic [LEVEL_W-1:0]  rsp_bar_ff;
   logic [LEVEL_W-1:0]  rsp_peak_ff;

   logic                req_fire;
   logic                sample_fire;
   logic                tick_fire;
   logic                rsp_free;
   logic                load;
   logic                csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVEL_W-1:0]  peak_new;

   sbph_div_cmd_type    div_cmd;
   sbph_div_res_type    div_res;
   sbph_peak_cmd_type   peak_cmd;

   // Register port: writes land on the access phase, reads are combinational
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (csr_index == REG_GAIN_DIVISOR) begin
         csr_prdata = CSR_DATA_W'(gain_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_write && (csr_index == REG_GAIN_DIVISOR)) begin
         gain_ff <= csr_pwdata[GAIN_W-1:0];
      end
   end

   // Input side: take a word only while no sample is in flight
   assign req_port.ready = (state_ff == S_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign sample_fire    = req_fire && (req_port.req_type == REQ_SAMPLE);
   assign tick_fire      = req_fire && (req_port.req_type == REQ_TICK);

   // Result register is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_port.ready;
   assign load     = rsp_free &&
                     (((state_ff == S_DIV) && div_res.done) || (state_ff == S_OUT));

   // Start the quotient straight from the accepted word
   always_comb begin
      div_cmd.start = sample_fire;
      div_cmd.amp   = req_port.amplitude;
      div_cmd.gain  = gain_ff;
   end

   sbph_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // The quotient unit holds its level until the next start, so the
   // peak update may wait in S_OUT for the result register.
   always_comb begin
      peak_cmd.update = load;
      peak_cmd.decay  = tick_fire;
      peak_cmd.bin    = bin_ff;
      peak_cmd.level  = div_res.level;
   end

   sbph_peak_store u_peaks (
      .clock    (clock),
      .reset    (reset),
      .cmd      (peak_cmd),
      .peak_new (peak_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
            rsp_bin_ff   <= bin_ff;
            rsp_bar_ff   <= div_res.level;
            rsp_peak_ff  <= peak_new;
         end
         case (state_ff)
            S_IDLE: begin
               if (sample_fire) begin
                  bin_ff   <= req_port.bin_index;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_res.done) begin
                  state_ff <= load ? S_IDLE : S_OUT;
               end
            end
            S_OUT: begin
               if (load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.bin_out     = rsp_bin_ff;
   assign rsp_port.bar_height  = rsp_bar_ff;
   assign rsp_port.peak_height = rsp_peak_ff;

   // A new result only ever follows a sample in flight
   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != S_IDLE))
      else $error("result raised without a sample in flight");

   // The quotient unit finishes only while a sample waits on it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_DIV))
      else $error("quotient finished outside the divide state");

   // A held peak is never below the bar it was just raised by
   a_peak_holds_bar: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (int'(rsp_bin_ff) < NUM_BINS)) |-> (rsp_peak_ff >= rsp_bar_ff))
      else $error("peak below bar");

endmodule

>>> bench/tb_spectrum_bar_peak_hold.sv
module tb_spectrum_bar_peak_hold;
   timeunit 1ns;
   timeprecision 1ps;

   import sbph_pkg::*;

   // Hard stop for a hung run, in clock cycles.
   localparam int CYCLE_LIMIT  = 200000;
   // Quiet cycles after the last result before touching the gain register.
   localparam int SETTLE_WAIT  = 12;
   localparam int IDLE_PERCENT = 18;
   localparam int TICK_PERCENT = 15;
   localparam int PHASE_WORDS  = 75;
   localparam int NUM_PHASES   = 6;

   typedef struct packed {
      logic [BIN_W-1:0]   bin;
      logic [LEVEL_W-1:0] bar;
      logic [LEVEL_W-1:0] peak;
   } meter_word_type;

   // Shadow of the meter: gain, held peaks and the bars still owed.
   class peak_meter_board;
      logic [GAIN_W-1:0]  gain;
      logic [LEVEL_W-1:0] peaks [NUM_BINS];
      meter_word_type     owed [$];
      int                 errors;
      int                 samples;
      int                 ticks;
      int                 results;

      function new();
         gain = GAIN_RESET;
         foreach (peaks[i]) peaks[i] = '0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function logic [LEVEL_W-1:0] bar_level(logic [AMP_W-1:0] amp);
         logic [AMP_W-1:0] quot;
         if (gain == '0) return LEVEL_W'(MAX_LEVEL);
         quot = amp / AMP_W'(gain);
         if (quot > AMP_W'(MAX_LEVEL)) return LEVEL_W'(MAX_LEVEL);
         return quot[LEVEL_W-1:0];
      endfunction

      function void note_word(logic kind, logic [BIN_W-1:0] bin, logic [AMP_W-1:0] amp);
         meter_word_type w;
         if (kind == REQ_TICK) begin
            foreach (peaks[i]) if (peaks[i] != '0) peaks[i] = peaks[i] - 1'b1;
            ticks++;
            return;
         end
         w.bin  = bin;
         w.bar  = bar_level(amp);
         if (peaks[bin] < w.bar) peaks[bin] = w.bar;
         w.peak = peaks[bin];
         owed.push_back(w);
         samples++;
      endfunction

      task report(string msg);
         $display("%0t  mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [BIN_W-1:0] bin, logic [LEVEL_W-1:0] bar,
                        logic [LEVEL_W-1:0] peak);
         meter_word_type w;
         results++;
         if (owed.size() == 0) begin
            report($sformatf("result bin %0d bar %0d peak %0d with nothing owed",
                             bin, bar, peak));
            return;
         end
         w = owed.pop_front();
         if (bin !== w.bin)
            report($sformatf("bin_out %0d, want %0d", bin, w.bin));
         if (bar !== w.bar)
            report($sformatf("bar_height %0d, want %0d (bin %0d)", bar, w.bar, w.bin));
         if (peak !== w.peak)
            report($sformatf("peak_height %0d, want %0d (bin %0d)", peak, w.peak, w.bin));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sbph_req_if req_if ();
   sbph_rsp_if rsp_if ();

   peak_meter_board board = new();

   // Set for a stretch where neither side ever idles.
   bit calm = 1'b0;
   int cycle_count = 0;
   int gains_tried = 0;

   spectrum_bar_peak_hold u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Abort a run that stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, board.pending());
         $display("spectrum_bar_peak_hold test failed");
         $finish;
      end
   end

   // Result side back-pressure: stall at random, never during the calm stretch.
   always @(negedge clock) begin
      rsp_if.ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watch both channels at the rising edge. An accepted input word updates the
   // shadow peaks in arrival order; an accepted result is checked against the
   // oldest bar owed. A result can never belong to a word accepted on the same
   // edge, so the order of the two checks does not matter.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         board.note_word(req_if.req_type, req_if.bin_index, req_if.amplitude);
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_result(rsp_if.bin_out, rsp_if.bar_height, rsp_if.peak_height);
   end

   // All driving tasks start and finish just after a falling edge.

   // Offer one word and hold it until it is taken; idle first now and then.
   task send_word(logic kind, logic [BIN_W-1:0] bin, logic [AMP_W-1:0] amp);
      if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.req_type  = kind;
      req_if.bin_index = bin;
      req_if.amplitude = amp;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed result has come back.
   task drain;
      req_if.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the gain register, then read it back. Stray upper data bits are
   // randomised; the register keeps only its low bits.
   task set_gain(logic [GAIN_W-1:0] gain);
      logic [CSR_DATA_W-1:0] wdata;
      drain();
      repeat (SETTLE_WAIT) @(negedge clock);
      wdata = $urandom;
      wdata[GAIN_W-1:0] = gain;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_GAIN_DIVISOR, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      board.gain  = gain;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_pwdata  = $urandom;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata[GAIN_W-1:0] !== gain)
         board.report($sformatf("gain reads back %0d, want %0d",
                                csr_prdata[GAIN_W-1:0], gain));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      gains_tried++;
   endtask

   // Mostly amplitudes that land across the bar range for this gain, with some
   // fully random words to toggle every amplitude bit.
   function logic [AMP_W-1:0] pick_amp(logic [GAIN_W-1:0] gain);
      int unsigned lvl;
      if (gain == '0 || $urandom_range(0, 9) < 3) return AMP_W'($urandom);
      lvl = $urandom_range(0, MAX_LEVEL + 2);
      return AMP_W'(lvl * gain + $urandom_range(0, gain - 1));
   endfunction

   // Favour a few low bins so that peaks build up and decay repeatedly.
   function logic [BIN_W-1:0] pick_bin();
      if ($urandom_range(0, 3) == 0) return BIN_W'($urandom_range(0, 3));
      return BIN_W'($urandom);
   endfunction

   initial begin
      logic [GAIN_W-1:0] gain_plan [NUM_PHASES];
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_SAMPLE;
      req_if.bin_index = '0;
      req_if.amplitude = '0;
      rsp_if.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, gain at its reset value of one.
      send_word(REQ_SAMPLE, 5'd0,  20'd0);          // empty bar
      send_word(REQ_SAMPLE, 5'd31, 20'hFFFFF);      // top bin, largest amplitude
      send_word(REQ_SAMPLE, 5'd5,  20'd7);          // raise a peak
      send_word(REQ_SAMPLE, 5'd5,  20'd3);          // lower bar, peak holds
      send_word(REQ_TICK,   5'd31, 20'hFFFFF);      // tick ignores its fields
      send_word(REQ_SAMPLE, 5'd5,  20'd0);          // peak has fallen by one
      send_word(REQ_SAMPLE, 5'd0,  20'd0);
      send_word(REQ_TICK,   5'd0,  20'd0);          // peak at zero stays at zero
      send_word(REQ_SAMPLE, 5'd0,  20'd0);
      send_word(REQ_SAMPLE, 5'd10, 20'hAAAAA);
      send_word(REQ_SAMPLE, 5'd21, 20'h55555);

      // Gain of zero saturates, even for a zero amplitude.
      set_gain(7'd0);
      send_word(REQ_SAMPLE, 5'd3, 20'd0);
      send_word(REQ_SAMPLE, 5'd3, 20'hFFFFF);

      // Top of the intended gain range: check the edge of saturation.
      set_gain(7'd100);
      send_word(REQ_SAMPLE, 5'd7, 20'd99);
      send_word(REQ_SAMPLE, 5'd7, 20'd1500);
      send_word(REQ_SAMPLE, 5'd7, 20'd1499);

      // Largest divisor the register holds.
      set_gain(7'd127);
      send_word(REQ_SAMPLE, 5'd8, 20'd1905);
      send_word(REQ_SAMPLE, 5'd8, 20'd1904);
      send_word(REQ_SAMPLE, 5'd8, 20'd126);
      send_word(REQ_TICK,   5'd8, 20'd0);
      send_word(REQ_SAMPLE, 5'd8, 20'd127);

      // Random part: one phase per gain setting, extremes and random values.
      gain_plan[0] = 7'd1;
      gain_plan[1] = 7'd0;
      gain_plan[2] = 7'd100;
      gain_plan[3] = 7'd127;
      gain_plan[4] = GAIN_W'($urandom_range(2, 99));
      gain_plan[5] = GAIN_W'($urandom_range(101, 126));
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_gain(gain_plan[ph]);
         calm = (ph == 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Hold the sender once until the meter has caught up completely.
            if (ph == 4 && n == PHASE_WORDS / 2) drain();
            if ($urandom_range(0, 99) < TICK_PERCENT)
               send_word(REQ_TICK, BIN_W'($urandom), AMP_W'($urandom));
            else
               send_word(REQ_SAMPLE, pick_bin(), pick_amp(gain_plan[ph]));
         end
         calm = 1'b0;
      end

      drain();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("covered %0d sample words and %0d tick words over %0d gain settings",
               board.samples, board.ticks, gains_tried);
      $display("checked %0d results, %0d mismatches", board.results, board.errors);
      if (board.errors == 0) begin
         $display("spectrum_bar_peak_hold test passed");
      end else begin
         $display("spectrum_bar_peak_hold test failed");
      end
      $finish;
   end

endmodule
